FILE: rtl/wav_hdr_pkg.sv
`default_nettype none
package wav_hdr_pkg;

  // Operand, result and iteration-counter widths of the duration division
  localparam int unsigned DVD_W = 41;  // data_bytes * 1000
  localparam int unsigned DVS_W = 47;  // channels * rate * bytes per sample
  localparam int unsigned QUO_W = 42;
  localparam int unsigned CNT_W = 6;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_NOT_RIFF  = 4'd1,
    ST_SIZE      = 4'd2,
    ST_NOT_WAVE  = 4'd3,
    ST_NO_FMT    = 4'd4,
    ST_FMT_LEN   = 4'd5,
    ST_COMPRESS  = 4'd6,
    ST_BAD_BITS  = 4'd7,
    ST_NO_DATA   = 4'd8,
    ST_BAD_DIV   = 4'd9
  } status_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

FILE: rtl/wav_hdr_div.sv
`default_nettype none
module wav_hdr_div (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wav_hdr_pkg::div_req_t        req,
  output logic                         done,
  output logic [wav_hdr_pkg::QUO_W-1:0] quotient
);
  import wav_hdr_pkg::*;

  logic             run_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;

  logic [DVS_W:0]   rem_sh;
  logic             fits;
  logic [DVS_W:0]   rem_sub;

  // One quotient bit per cycle: shift in the next dividend bit, trial subtract
  always_comb begin
    rem_sh  = {rem_r, quo_r[DVD_W-1]};
    fits    = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        quo_r <= req.dividend;
        rem_r <= '0;
        dvs_r <= req.divisor;
      end else if (run_r) begin
        rem_r <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        quo_r <= {quo_r[DVD_W-2:0], fits};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = {{(QUO_W-DVD_W){1'b0}}, quo_r};

endmodule
`default_nettype wire

FILE: rtl/wav_header_parser.sv
`default_nettype none
// Parses a RIFF/WAVE header one byte per cycle while in_tready is high; in_tready is
// low while a result waits for out_tready. The byte that completes the data length
// starts the bit-serial duration division: the rate product is registered, the divider
// is loaded and runs through every dividend bit, with in_tready low. Errors show in the
// cycle after the byte. Synchronous active-low reset clears the parser and file_size.
module wav_header_parser (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          cfg_valid,
  output logic         cfg_ready,
  input  wire  [31:0]  cfg_data,    // file_size
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [7:0]   in_tdata,    // data_byte
  input  wire          in_tlast,    // last_byte
  output logic         out_tvalid,
  input  wire          out_tready,
  // status[3:0], channels[18:4], sample_rate[49:19], sample_bits[54:50],
  // data_offset[86:55], data_bytes[117:87], duration_ms[159:118]
  output logic [159:0] out_tdata
);
  import wav_hdr_pkg::*;

  typedef enum logic [4:0] {
    PH_RIFF, PH_RLEN, PH_WAVE, PH_FMT_ID, PH_FMT_SLEN, PH_FMT_SKIP, PH_FMT_LEN,
    PH_FORMAT, PH_CHAN, PH_RATE, PH_IGNORE6, PH_BITS, PH_DATA_ID, PH_DATA_SLEN,
    PH_DATA_SKIP, PH_DATA_LEN, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {C_RUN, C_MUL, C_START, C_WAIT} ctl_t;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  function automatic logic [2:0] phase_len(input phase_t ph);
    case (ph)
      PH_FORMAT, PH_CHAN, PH_BITS: phase_len = 3'd2;
      PH_IGNORE6:                  phase_len = 3'd6;
      default:                     phase_len = 3'd4;
    endcase
  endfunction

  function automatic status_t early_code(input phase_t ph);
    case (ph)
      PH_RIFF:                                 early_code = ST_NOT_RIFF;
      PH_RLEN:                                 early_code = ST_SIZE;
      PH_WAVE:                                 early_code = ST_NOT_WAVE;
      PH_FMT_ID, PH_FMT_SLEN, PH_FMT_SKIP:     early_code = ST_NO_FMT;
      PH_FMT_LEN:                              early_code = ST_FMT_LEN;
      PH_FORMAT:                               early_code = ST_COMPRESS;
      PH_CHAN, PH_RATE, PH_IGNORE6, PH_BITS:   early_code = ST_BAD_BITS;
      PH_DATA_ID, PH_DATA_SLEN, PH_DATA_SKIP,
      PH_DATA_LEN:                             early_code = ST_NO_DATA;
      default:                                 early_code = ST_OK;
    endcase
  endfunction

  logic [31:0] file_size_r;
  phase_t      phase_r, phase_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic [31:0] skip_r, skip_nxt;
  logic [31:0] fshift_r, fshift_nxt;
  logic [2:0]  fcnt_r, fcnt_nxt;
  logic [15:0] chan_r, chan_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] bits_r, bits_nxt;
  logic        given_r, given_nxt;
  ctl_t        ctl_r;

  logic        out_valid_r;
  status_t     out_status_r;
  logic [14:0] out_chan_r;
  logic [30:0] out_rate_r;
  logic [4:0]  out_bits_r;
  logic [31:0] out_offset_r;
  logic [30:0] out_dbytes_r;
  logic [41:0] out_dur_r;
  logic [45:0] prod_r;

  logic        err;
  status_t     err_code;
  logic        fin;
  logic [31:0] fin_len;
  logic [31:0] fv;
  logic [2:0]  fcnt_inc;

  div_req_t          dreq;
  logic              ddone;
  logic [QUO_W-1:0]  dquo;
  logic [DVD_W-1:0]  len_ext;

  logic accept;
  assign accept = in_tvalid && in_tready;

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r + 32'd1;
    skip_nxt   = skip_r;
    fshift_nxt = fshift_r;
    fcnt_nxt   = fcnt_r;
    chan_nxt   = chan_r;
    rate_nxt   = rate_r;
    bits_nxt   = bits_r;
    given_nxt  = given_r;
    err        = 1'b0;
    err_code   = ST_OK;
    fin        = 1'b0;
    fin_len    = '0;
    fcnt_inc   = fcnt_r + 3'd1;
    fv         = fshift_r;
    if (fcnt_r < 3'd4) begin
      fv = fshift_r | ({24'd0, in_tdata} << {fcnt_r[1:0], 3'b000});
    end

    if (!given_r && phase_r != PH_DONE) begin
      if (phase_r == PH_FMT_SKIP || phase_r == PH_DATA_SKIP) begin
        skip_nxt = skip_r - 32'd1;
        if (skip_r == 32'd1) begin
          phase_nxt = (phase_r == PH_FMT_SKIP) ? PH_FMT_ID : PH_DATA_ID;
        end
      end else begin
        fshift_nxt = fv;
        fcnt_nxt   = fcnt_inc;
        if (fcnt_inc >= phase_len(phase_r)) begin
          fshift_nxt = '0;
          fcnt_nxt   = '0;
          case (phase_r)
            PH_RIFF: begin
              if (fv != TAG_RIFF) begin err = 1'b1; err_code = ST_NOT_RIFF; end
              else phase_nxt = PH_RLEN;
            end
            PH_RLEN: begin
              if (fv[31] || ({1'b0, fv} + 33'd8) != {1'b0, file_size_r}) begin
                err = 1'b1; err_code = ST_SIZE;
              end else phase_nxt = PH_WAVE;
            end
            PH_WAVE: begin
              if (fv != TAG_WAVE) begin err = 1'b1; err_code = ST_NOT_WAVE; end
              else phase_nxt = PH_FMT_ID;
            end
            PH_FMT_ID:  phase_nxt = (fv == TAG_FMT) ? PH_FMT_LEN : PH_FMT_SLEN;
            PH_DATA_ID: phase_nxt = (fv == TAG_DATA) ? PH_DATA_LEN : PH_DATA_SLEN;
            PH_FMT_SLEN, PH_DATA_SLEN: begin
              if (fv[31]) begin
                err = 1'b1; err_code = ST_BAD_DIV;
              end else if (fv == 32'd0) begin
                phase_nxt = (phase_r == PH_FMT_SLEN) ? PH_FMT_ID : PH_DATA_ID;
              end else begin
                skip_nxt  = fv;
                phase_nxt = (phase_r == PH_FMT_SLEN) ? PH_FMT_SKIP : PH_DATA_SKIP;
              end
            end
            PH_FMT_LEN: begin
              if (fv != 32'd16) begin err = 1'b1; err_code = ST_FMT_LEN; end
              else phase_nxt = PH_FORMAT;
            end
            PH_FORMAT: begin
              if (fv[15:0] != 16'd1) begin err = 1'b1; err_code = ST_COMPRESS; end
              else phase_nxt = PH_CHAN;
            end
            PH_CHAN: begin
              chan_nxt  = fv[15:0];
              phase_nxt = PH_RATE;
            end
            PH_RATE: begin
              rate_nxt  = fv;
              phase_nxt = PH_IGNORE6;
            end
            PH_IGNORE6: phase_nxt = PH_BITS;
            PH_BITS: begin
              bits_nxt = fv[15:0];
              if (fv[15:0] != 16'd8 && fv[15:0] != 16'd16) begin
                err = 1'b1; err_code = ST_BAD_BITS;
              end else phase_nxt = PH_DATA_ID;
            end
            PH_DATA_LEN: begin
              if (chan_r[15] || chan_r == 16'd0 || rate_r[31] || rate_r == 32'd0 ||
                  fv[31]) begin
                err = 1'b1; err_code = ST_BAD_DIV;
              end else begin
                fin       = 1'b1;
                fin_len   = fv;
                phase_nxt = PH_DONE;
                given_nxt = 1'b1;
              end
            end
            default: ;
          endcase
          if (err) begin
            phase_nxt = PH_DONE;
            given_nxt = 1'b1;
          end
        end
      end
    end

    // File ended before any result: report the step in progress
    if (in_tlast && !given_nxt && phase_nxt != PH_DONE) begin
      err      = 1'b1;
      err_code = early_code(phase_nxt);
    end

    if (in_tlast) begin
      phase_nxt  = PH_RIFF;
      pos_nxt    = '0;
      skip_nxt   = '0;
      fshift_nxt = '0;
      fcnt_nxt   = '0;
      chan_nxt   = '0;
      rate_nxt   = '0;
      bits_nxt   = '0;
      given_nxt  = 1'b0;
    end
  end

  // data_bytes * 1000 as (x << 10) - (x << 4) - (x << 3)
  assign len_ext = {{(DVD_W-31){1'b0}}, out_dbytes_r};

  always_comb begin
    dreq.start    = (ctl_r == C_START);
    dreq.dividend = (len_ext << 10) - (len_ext << 4) - (len_ext << 3);
    dreq.divisor  = out_bits_r[4] ? {prod_r, 1'b0} : {1'b0, prod_r};
  end

  wav_hdr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (dreq),
    .done     (ddone),
    .quotient (dquo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_size_r <= '0;
      phase_r     <= PH_RIFF;
      pos_r       <= '0;
      skip_r      <= '0;
      fshift_r    <= '0;
      fcnt_r      <= '0;
      chan_r      <= '0;
      rate_r      <= '0;
      bits_r      <= '0;
      given_r     <= 1'b0;
      ctl_r       <= C_RUN;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        file_size_r <= cfg_data;
      end
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) begin
        phase_r  <= phase_nxt;
        pos_r    <= pos_nxt;
        skip_r   <= skip_nxt;
        fshift_r <= fshift_nxt;
        fcnt_r   <= fcnt_nxt;
        chan_r   <= chan_nxt;
        rate_r   <= rate_nxt;
        bits_r   <= bits_nxt;
        given_r  <= given_nxt;
        if (err) begin
          out_valid_r  <= 1'b1;
          out_status_r <= err_code;
          out_chan_r   <= '0;
          out_rate_r   <= '0;
          out_bits_r   <= '0;
          out_offset_r <= '0;
          out_dbytes_r <= '0;
          out_dur_r    <= '0;
        end else if (fin) begin
          // hold the fields; the duration follows from the divider
          out_status_r <= ST_OK;
          out_chan_r   <= chan_r[14:0];
          out_rate_r   <= rate_r[30:0];
          out_bits_r   <= bits_r[4:0];
          out_offset_r <= pos_r + 32'd1;
          out_dbytes_r <= fin_len[30:0];
          ctl_r        <= C_MUL;
        end
      end
      case (ctl_r)
        C_MUL: begin
          prod_r <= out_chan_r * out_rate_r;
          ctl_r  <= C_START;
        end
        C_START: ctl_r <= C_WAIT;
        C_WAIT: begin
          if (ddone) begin
            out_dur_r   <= dquo;
            out_valid_r <= 1'b1;
            ctl_r       <= C_RUN;
          end
        end
        default: ;
      endcase
    end
  end

  assign cfg_ready  = 1'b1;
  assign in_tready  = (ctl_r == C_RUN) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_dur_r, out_dbytes_r, out_offset_r, out_bits_r, out_rate_r,
                       out_chan_r, out_status_r};

endmodule
`default_nettype wire

FILE: tb/tb_wav_header_parser.sv
`default_nettype none
module tb_wav_header_parser;
  import wav_hdr_pkg::*;

  localparam logic [31:0] RIFF_ID = 32'h46464952;
  localparam logic [31:0] WAVE_ID = 32'h45564157;
  localparam logic [31:0] FMT_ID  = 32'h20746d66;
  localparam logic [31:0] DATA_ID = 32'h61746164;

  localparam int NEG_NONE = 0;
  localparam int NEG_FMT  = 1;
  localparam int NEG_DATA = 2;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 60;

  typedef enum logic [4:0] {
    P_RIFF_TAG, P_RIFF_LEN, P_WAVE_TAG, P_FMT_SEEK, P_FMT_SKIPLEN, P_FMT_SKIP,
    P_FMT_SIZE, P_FMT_CODE, P_CHANNELS, P_RATE, P_RATE_PAD, P_BITS,
    P_DATA_SEEK, P_DATA_SKIPLEN, P_DATA_SKIP, P_DATA_SIZE, P_DONE
  } parse_phase_e;

  // Same layout as out_tdata, highest field first
  typedef struct packed {
    logic [41:0] duration_ms;
    logic [30:0] nbytes;
    logic [31:0] offset;
    logic [4:0]  bits;
    logic [30:0] rate;
    logic [14:0] channels;
    status_t     status;
  } hdr_res_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } file_byte_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [31:0]  cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata = '0;
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [159:0] out_tdata;

  wav_header_parser u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // Parser mirror
  logic [31:0]  cfg_file_size = '0;
  parse_phase_e phase = P_RIFF_TAG;
  logic [31:0]  byte_pos = '0;
  logic [31:0]  skip_left = '0;
  logic [31:0]  field_acc = '0;
  int           field_cnt = 0;
  logic [15:0]  held_ch = '0;
  logic [31:0]  held_rate = '0;
  logic [15:0]  held_bits = '0;
  logic         hdr_done = 1'b0;

  hdr_res_t   hdr_exp_q[$];
  file_byte_t pending_q[$];
  logic [7:0] img[$];
  file_byte_t nxt;
  hdr_res_t   seen, want;
  int         mismatches = 0;
  int         quiet = 0;
  int         tx_idle_pct = 0;
  int         rx_idle_pct = 0;
  logic [31:0] common_rates [6] = '{32'd8000, 32'd11025, 32'd22050,
                                    32'd44100, 32'd48000, 32'd96000};

  function automatic int field_bytes(parse_phase_e p);
    case (p)
      P_FMT_CODE, P_CHANNELS, P_BITS: return 2;
      P_RATE_PAD: return 6;
      default: return 4;
    endcase
  endfunction

  function automatic status_t early_status(parse_phase_e p);
    case (p)
      P_RIFF_TAG: return ST_NOT_RIFF;
      P_RIFF_LEN: return ST_SIZE;
      P_WAVE_TAG: return ST_NOT_WAVE;
      P_FMT_SEEK, P_FMT_SKIPLEN, P_FMT_SKIP: return ST_NO_FMT;
      P_FMT_SIZE: return ST_FMT_LEN;
      P_FMT_CODE: return ST_COMPRESS;
      P_CHANNELS, P_RATE, P_RATE_PAD, P_BITS: return ST_BAD_BITS;
      default: return ST_NO_DATA;
    endcase
  endfunction

  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [31:0] v;
    logic [63:0] dvd, dvs;
    logic        had, emitted;
    status_t     fail_code;
    hdr_res_t    r;
    had = hdr_done;
    fail_code = ST_OK;
    r = '0;
    if (!hdr_done) begin
      if (phase == P_FMT_SKIP || phase == P_DATA_SKIP) begin
        skip_left = skip_left - 32'd1;
        if (skip_left == 0) phase = (phase == P_FMT_SKIP) ? P_FMT_SEEK : P_DATA_SEEK;
      end else begin
        if (field_cnt < 4) field_acc = field_acc | (32'(b) << (8 * field_cnt));
        field_cnt++;
        if (field_cnt >= field_bytes(phase)) begin
          v = field_acc;
          field_acc = '0;
          field_cnt = 0;
          case (phase)
            P_RIFF_TAG: if (v == RIFF_ID) phase = P_RIFF_LEN; else fail_code = ST_NOT_RIFF;
            P_RIFF_LEN: begin
              if (!v[31] && ({1'b0, v} + 33'd8) == {1'b0, cfg_file_size}) phase = P_WAVE_TAG;
              else fail_code = ST_SIZE;
            end
            P_WAVE_TAG: if (v == WAVE_ID) phase = P_FMT_SEEK; else fail_code = ST_NOT_WAVE;
            P_FMT_SEEK: phase = (v == FMT_ID) ? P_FMT_SIZE : P_FMT_SKIPLEN;
            P_FMT_SKIPLEN, P_DATA_SKIPLEN: begin
              if (v[31]) begin
                fail_code = ST_BAD_DIV;
              end else if (v == 0) begin
                phase = (phase == P_FMT_SKIPLEN) ? P_FMT_SEEK : P_DATA_SEEK;
              end else begin
                skip_left = v;
                phase = (phase == P_FMT_SKIPLEN) ? P_FMT_SKIP : P_DATA_SKIP;
              end
            end
            P_FMT_SIZE: if (v == 32'd16) phase = P_FMT_CODE; else fail_code = ST_FMT_LEN;
            P_FMT_CODE: if (v[15:0] == 16'd1) phase = P_CHANNELS; else fail_code = ST_COMPRESS;
            P_CHANNELS: begin
              held_ch = v[15:0];
              phase = P_RATE;
            end
            P_RATE: begin
              held_rate = v;
              phase = P_RATE_PAD;
            end
            P_RATE_PAD: phase = P_BITS;
            P_BITS: begin
              held_bits = v[15:0];
              if (held_bits == 16'd8 || held_bits == 16'd16) phase = P_DATA_SEEK;
              else fail_code = ST_BAD_BITS;
            end
            P_DATA_SEEK: phase = (v == DATA_ID) ? P_DATA_SIZE : P_DATA_SKIPLEN;
            P_DATA_SIZE: begin
              if (held_ch[15] || held_ch == 0 || held_rate[31] || held_rate == 0 || v[31]) begin
                fail_code = ST_BAD_DIV;
              end else begin
                dvd = 64'(v) * 64'd1000;
                dvs = 64'(held_ch) * 64'(held_rate) * 64'(held_bits >> 3);
                r.channels = held_ch[14:0];
                r.rate = held_rate[30:0];
                r.bits = held_bits[4:0];
                r.offset = byte_pos + 32'd1;
                r.nbytes = v[30:0];
                r.duration_ms = 42'(dvd / dvs);
                phase = P_DONE;
                hdr_done = 1'b1;
              end
            end
            default: ;
          endcase
          if (fail_code != ST_OK) begin
            r.status = fail_code;
            phase = P_DONE;
            hdr_done = 1'b1;
          end
        end
      end
    end
    byte_pos = byte_pos + 32'd1;
    emitted = hdr_done && !had;
    if (last) begin
      if (!hdr_done) begin
        r.status = early_status(phase);
        emitted = 1'b1;
      end
      // rearm for the next file
      phase = P_RIFF_TAG;
      byte_pos = '0;
      skip_left = '0;
      field_acc = '0;
      field_cnt = 0;
      held_ch = '0;
      held_rate = '0;
      held_bits = '0;
      hdr_done = 1'b0;
    end
    if (emitted) hdr_exp_q.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [63:0] got_v, want_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
    end
  endtask

  // Stimulus helpers
  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) img.push_back(v[8*i +: 8]);
  endtask

  task automatic put_junk(input int count, input logic neg);
    int len;
    for (int k = 0; k < count; k++) begin
      len = $urandom_range(12, 0);
      put_le({24'($urandom), 8'h4A}, 4);
      put_le(32'(len), 4);
      for (int i = 0; i < len; i++) put_le($urandom, 1);
    end
    if (neg) begin
      put_le({24'($urandom), 8'h4A}, 4);
      put_le($urandom | 32'h80000000, 4);
    end
  endtask

  task automatic build_wav(input logic [31:0] riff_len, input logic [31:0] fmt_len,
                           input logic [15:0] code, input logic [15:0] ch,
                           input logic [31:0] rate, input logic [15:0] bits,
                           input logic [31:0] dlen, input int junk_fmt, input int junk_data,
                           input int tail, input int neg);
    img.delete();
    put_le(RIFF_ID, 4);
    put_le(riff_len, 4);
    put_le(WAVE_ID, 4);
    put_junk(junk_fmt, neg == NEG_FMT);
    put_le(FMT_ID, 4);
    put_le(fmt_len, 4);
    put_le(32'(code), 2);
    put_le(32'(ch), 2);
    put_le(rate, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le(32'(bits), 2);
    put_junk(junk_data, neg == NEG_DATA);
    put_le(DATA_ID, 4);
    put_le(dlen, 4);
    for (int i = 0; i < tail; i++) put_le($urandom, 1);
  endtask

  task automatic rand_wav();
    logic [31:0] rlen, flen, rate, dlen;
    logic [15:0] code, ch, bits;
    int          neg, pick;
    rlen = ($urandom_range(99, 0) < 95) ? cfg_file_size - 32'd8 : $urandom;
    flen = ($urandom_range(99, 0) < 95) ? 32'd16 : 32'($urandom_range(40, 0));
    code = ($urandom_range(99, 0) < 95) ? 16'd1 : 16'($urandom);
    ch = ($urandom_range(99, 0) < 80) ? 16'($urandom_range(8, 1)) : 16'($urandom);
    rate = ($urandom_range(99, 0) < 70) ? common_rates[$urandom_range(5, 0)] : $urandom;
    if ($urandom_range(99, 0) < 90) bits = $urandom_range(1, 0) ? 16'd16 : 16'd8;
    else bits = 16'($urandom);
    pick = $urandom_range(99, 0);
    if (pick < 85) dlen = $urandom & 32'h7FFFFFFF;
    else if (pick < 95) dlen = $urandom_range(4096, 0);
    else dlen = $urandom;
    pick = $urandom_range(99, 0);
    neg = (pick < 4) ? NEG_FMT : (pick < 8) ? NEG_DATA : NEG_NONE;
    build_wav(rlen, flen, code, ch, rate, bits, dlen, $urandom_range(2, 0),
              $urandom_range(2, 0), $urandom_range(4, 0), neg);
  endtask

  task automatic send_img(input int keep);
    file_byte_t fb;
    for (int i = 0; i < keep; i++) begin
      fb.data = img[i];
      fb.last = (i == keep - 1);
      pending_q.push_back(fb);
    end
  endtask

  // Hold until every byte is in and every result is out, then let the block settle
  task automatic drain();
    while (pending_q.size() != 0 || in_tvalid || hdr_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_file_size(input logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_file_size = v;
  endtask

  // Byte driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_q.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
        nxt = pending_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= nxt.data;
        in_tlast <= nxt.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) out_tready <= ($urandom_range(99, 0) >= rx_idle_pct);

  // Predict on accepted bytes, check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) parse_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        seen = out_tdata;
        if (hdr_exp_q.size() == 0) begin
          mismatches++;
          $display("%0t: header result with none pending, actual %h", $time, out_tdata);
        end else begin
          want = hdr_exp_q.pop_front();
          check_field("status", 64'(seen.status), 64'(want.status));
          check_field("channels", 64'(seen.channels), 64'(want.channels));
          check_field("sample_rate", 64'(seen.rate), 64'(want.rate));
          check_field("sample_bits", 64'(seen.bits), 64'(want.bits));
          check_field("data_offset", 64'(seen.offset), 64'(want.offset));
          check_field("data_bytes", 64'(seen.nbytes), 64'(want.nbytes));
          check_field("duration_ms", 64'(seen.duration_ms), 64'(want.duration_ms));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("[wav_header_parser] ERROR");
      $finish;
    end
  end

  initial begin
    int pick, idx;
    tx_idle_pct = 6;
    rx_idle_pct = 52;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Zero size: no RIFF length can match
    write_file_size(32'd0);
    build_wav(32'd0, 32'd16, 16'd1, 16'd1, 32'd8000, 16'd8, 32'd100, 0, 0, 0, NEG_NONE);
    send_img(img.size());
    img.delete();
    put_le(RIFF_ID, 1);
    send_img(1);
    drain();

    // All-ones size needs a negative RIFF length
    write_file_size(32'hFFFFFFFF);
    build_wav(32'hFFFFFFF7, 32'd16, 16'd1, 16'd1, 32'd8000, 16'd8, 32'd100, 0, 0, 0, NEG_NONE);
    send_img(img.size());
    drain();

    write_file_size(32'd8);
    build_wav(32'd0, 32'd16, 16'd1, 16'd1, 32'd8000, 16'd8, 32'd16000, 0, 0, 0, NEG_NONE);
    send_img(img.size());
    build_wav(32'd0, 32'd16, 16'd1, 16'd2, 32'd44100, 16'd16, 32'd176400, 2, 1, 5, NEG_NONE);
    send_img(img.size());
    build_wav(32'd0, 32'd16, 16'd1, 16'd1, 32'd1, 16'd8, 32'h7FFFFFFF, 0, 0, 0, NEG_NONE);
    send_img(img.size());
    build_wav(32'd0, 32'd16, 16'd1, 16'h7FFF, 32'h7FFFFFFF, 16'd16, 32'd100, 0, 0, 0, NEG_NONE);
    send_img(img.size());
    build_wav(32'd0, 32'd16, 16'd1, 16'd1, 32'd8000, 16'd8, 32'd100, 0, 0, 3, NEG_NONE);
    img[0] = 8'h00;
    send_img(img.size());
    build_wav(32'd0, 32'd16, 16'd1, 16'd1, 32'd8000, 16'd8, 32'd100, 0, 0, 0, NEG_NONE);
    img[11] = img[11] ^ 8'h80;
    send_img(img.size());
    build_wav(32'd0, 32'd18, 16'd1, 16'd1, 32'd8000, 16'd8, 32'd100, 0, 0, 0, NEG_NONE);
    send_img(img.size());
    build_wav(32'd0, 32'd16, 16'd3, 16'd1, 32'd8000, 16'd8, 32'd100, 0, 0, 0, NEG_NONE);
    send_img(img.size());
    build_wav(32'd0, 32'd16, 16'd1, 16'd1, 32'd8000, 16'd24, 32'd100, 0, 0, 0, NEG_NONE);
    send_img(img.size());
    build_wav(32'd0, 32'd16, 16'd1, 16'd1, 32'd8000, 16'hFFFF, 32'd100, 0, 0, 0, NEG_NONE);
    send_img(img.size());
    // negative chunk lengths while searching
    build_wav(32'd0, 32'd16, 16'd1, 16'd1, 32'd8000, 16'd8, 32'd100, 1, 0, 0, NEG_FMT);
    send_img(img.size());
    build_wav(32'd0, 32'd16, 16'd1, 16'd1, 32'd8000, 16'd8, 32'd100, 0, 1, 0, NEG_DATA);
    send_img(img.size());
    // division operands out of range
    build_wav(32'd0, 32'd16, 16'd1, 16'd0, 32'd8000, 16'd8, 32'd100, 0, 0, 0, NEG_NONE);
    send_img(img.size());
    build_wav(32'd0, 32'd16, 16'd1, 16'd1, 32'd0, 16'd8, 32'd100, 0, 0, 0, NEG_NONE);
    send_img(img.size());
    build_wav(32'd0, 32'd16, 16'd1, 16'h8000, 32'd8000, 16'd8, 32'd100, 0, 0, 0, NEG_NONE);
    send_img(img.size());
    build_wav(32'd0, 32'd16, 16'd1, 16'd1, 32'h80000000, 16'd16, 32'd100, 0, 0, 0, NEG_NONE);
    send_img(img.size());
    build_wav(32'd0, 32'd16, 16'd1, 16'd1, 32'd8000, 16'd8, 32'h80000000, 0, 0, 0, NEG_NONE);
    send_img(img.size());
    // file ends early at every third byte across the header
    for (int cut = 1; cut < 44; cut += 3) begin
      build_wav(32'd0, 32'd16, 16'd1, 16'd2, 32'd22050, 16'd16, 32'd4000, 0, 0, 0, NEG_NONE);
      send_img(cut);
    end
    drain();

    write_file_size(32'h80000007);
    build_wav(32'h7FFFFFFF, 32'd16, 16'd1, 16'd6, 32'd96000, 16'd16, 32'h7FFFFFFF, 1, 1, 2,
              NEG_NONE);
    send_img(img.size());
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          tx_idle_pct = 6;
          rx_idle_pct = 52;
        end
        1: begin
          tx_idle_pct = 52;
          rx_idle_pct = 6;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      write_file_size(32'd8 + $urandom_range(32'h7FFFFFFF, 0));
      for (int f = 0; f < 8; f++) begin
        pick = $urandom_range(99, 0);
        if (pick < 93) begin
          rand_wav();
          if (pick >= 85) begin
            send_img($urandom_range(img.size(), 1));
          end else begin
            // corrupt one file byte now and then
            if (pick >= 70) begin
              idx = $urandom_range(img.size() - 1, 0);
              img[idx] = img[idx] ^ 8'($urandom_range(255, 1));
            end
            send_img(img.size());
          end
        end else begin
          img.delete();
          for (int i = $urandom_range(12, 1); i > 0; i--) put_le($urandom, 1);
          send_img(img.size());
        end
      end
      drain();
    end

    if (mismatches == 0 && hdr_exp_q.size() == 0) begin
      $display("[wav_header_parser] OK");
    end else begin
      $display("[wav_header_parser] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
